// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// shared codes, widths and control structs of the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int ST_W          = 2;
  localparam int POS_W         = 4;
  localparam int CNT_W         = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            push_front;
    logic            push_back;
    logic            rd_front;
    logic            rd_back;
    logic            scan_rd;
    logic            pop_front;
    logic            pop_back;
    logic            scan_init;
    logic            scan_step;
    logic            res_load;
    logic [ST_W-1:0] res_status;
    logic            res_data;
    logic            res_pos;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            match;
    logic            scan_last;
  } sts_t;

endpackage

// ===== rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = bdq_pkg::DATA_W,
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// ring pointers, entry ram, scan counter and result registers
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::cmd_t                     cmd_i,
  output bdq_pkg::sts_t                     sts_o,
  input  logic [bdq_pkg::OP_W-1:0]          operation_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic signed [bdq_pkg::DATA_W-1:0] result_value_o,
  output logic [bdq_pkg::POS_W-1:0]         position_o,
  output logic [bdq_pkg::ST_W-1:0]          status_o,
  output logic [bdq_pkg::CNT_W-1:0]         count_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = AW + 1;
  localparam int KW  = (AW > bdq_pkg::POS_W) ? AW : bdq_pkg::POS_W;
  localparam int CXW = (CW > bdq_pkg::CNT_W) ? CW : bdq_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               scan_slot_q, scan_slot_d;
  logic [AW-1:0]               k_q, k_d;
  logic [bdq_pkg::OP_W-1:0]    op_q;
  logic [bdq_pkg::DATA_W-1:0]  value_q;
  logic [bdq_pkg::DATA_W-1:0]  result_value_q;
  logic [bdq_pkg::POS_W-1:0]   position_q;
  logic [bdq_pkg::ST_W-1:0]    status_q;

  logic [SW-1:0]               tail_sum;
  logic [AW-1:0]               tail_slot, back_slot, front_dec, front_inc, scan_inc;
  logic                        we;
  logic [AW-1:0]               waddr, raddr;
  logic                        re;
  logic [bdq_pkg::DATA_W-1:0]  rdata;
  logic [KW-1:0]               k_ext;
  logic [CXW-1:0]              count_ext;

  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign back_slot = (tail_slot == '0) ? LAST_SLOT : tail_slot - AW'(1);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
  assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + AW'(1);
  assign scan_inc  = (scan_slot_q == LAST_SLOT) ? '0 : scan_slot_q + AW'(1);

  assign we    = cmd_i.push_front | cmd_i.push_back;
  assign waddr = cmd_i.push_front ? front_dec : tail_slot;
  assign re    = cmd_i.rd_front | cmd_i.rd_back | cmd_i.scan_rd;
  assign raddr = cmd_i.rd_front ? front_q : (cmd_i.rd_back ? back_slot : scan_slot_q);

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    scan_slot_d = scan_slot_q;
    k_d         = k_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      count_d = count_q + CW'(1);
    end else if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop_front) begin
      front_d = front_inc;
      count_d = count_q - CW'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.scan_init) begin
      scan_slot_d = front_inc;
      k_d         = '0;
    end else if (cmd_i.scan_step) begin
      scan_slot_d = scan_inc;
      k_d         = k_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_slot_q <= scan_slot_d;
    k_q         <= k_d;
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      value_q <= value_i;
    end
    if (cmd_i.res_load) begin
      status_q       <= cmd_i.res_status;
      result_value_q <= cmd_i.res_data ? rdata : '0;
      position_q     <= cmd_i.res_pos ? k_ext[bdq_pkg::POS_W-1:0] : '0;
    end
  end

  assign k_ext     = KW'(k_q);
  assign count_ext = CXW'(count_q);

  assign sts_o.op        = op_q;
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.match     = (rdata == value_q);
  assign sts_o.scan_last = ((CW'(k_q) + CW'(1)) == count_q);

  assign result_value_o = result_value_q;
  assign position_o     = position_q;
  assign status_o       = status_q;
  assign count_o        = count_ext[bdq_pkg::CNT_W-1:0];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("stored count beyond capacity");
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(front_q) < SW'(DEPTH))
    else $error("front slot out of range");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_front || cmd_i.push_back) |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the store by one");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_front || cmd_i.pop_back) |-> count_q != '0)
    else $error("pop issued on empty store");
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (CW'(k_q) + CW'(1)) < count_q)
    else $error("scan stepped past the last stored value");
`endif

endmodule

// ===== rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// request sequencer: decode, pop read, search scan and result handoff
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bdq_pkg::sts_t sts_i,
  output bdq_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_POP_DONE = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_OUT      = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op) inside
          bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
            cmd_o.res_load = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd_o.res_status = bdq_pkg::ST_OK;
              cmd_o.push_front = (sts_i.op == bdq_pkg::OP_PUSH_FRONT);
              cmd_o.push_back  = (sts_i.op == bdq_pkg::OP_PUSH_BACK);
            end
            state_d = S_OUT;
          end
          bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
            if (sts_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_EMPTY;
              state_d          = S_OUT;
            end else begin
              cmd_o.rd_front  = (sts_i.op == bdq_pkg::OP_POP_FRONT);
              cmd_o.pop_front = (sts_i.op == bdq_pkg::OP_POP_FRONT);
              cmd_o.rd_back   = (sts_i.op == bdq_pkg::OP_POP_BACK);
              cmd_o.pop_back  = (sts_i.op == bdq_pkg::OP_POP_BACK);
              state_d         = S_POP_DONE;
            end
          end
          bdq_pkg::OP_SEARCH: begin
            if (sts_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_NOT_FOUND;
              state_d          = S_OUT;
            end else begin
              cmd_o.rd_front  = 1'b1;
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = bdq_pkg::ST_OK;
            state_d          = S_OUT;
          end
        endcase
      end
      S_POP_DONE: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = bdq_pkg::ST_OK;
        cmd_o.res_data   = 1'b1;
        state_d          = S_OUT;
      end
      S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bdq_pkg::ST_OK;
          cmd_o.res_pos    = 1'b1;
          state_d          = S_OUT;
        end else if (sts_i.scan_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bdq_pkg::ST_NOT_FOUND;
          state_d          = S_OUT;
        end else begin
          cmd_o.scan_rd   = 1'b1;
          cmd_o.scan_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

`ifndef SYNTH
  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result is pending");
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.res_load))
    else $error("result shown without being loaded");
  a_single_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push_front, cmd_o.push_back, cmd_o.pop_front, cmd_o.pop_back}))
    else $error("more than one store update in a cycle");
`endif

endmodule

// ===== rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// double-ended queue of signed 32-bit values, capacity DEPTH, with search
// ----------------------------------------------------------------------------
// a request (operation_i, value_i) is taken when in_valid_i is high and
// in_stall_o is low; each request gives exactly one result on the output
// channel, taken when out_valid_o is high and out_stall_i is low.
// one request is in flight at a time: in_stall_o stays high from acceptance
// until the result has been taken. from acceptance to out_valid_o, a request
//   push, no-op code, rejected push or pop, search of an empty store: decode
//   pop: decode, then one registered read of the entry ram
//   search: decode, then scan until a hit or the last stored value
// the search walks the ring one entry ram read per cycle from the front.
// while out_stall_i is high the result is held unchanged; the next request
// is taken in the cycle after the result is taken.
// reset empties the store at once (front slot and count cleared); the entry
// ram is not cleared, since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdq_pkg::OP_W-1:0]          operation_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bdq_pkg::DATA_W-1:0] result_value_o,
  output logic [bdq_pkg::POS_W-1:0]         position_o,
  output logic [bdq_pkg::ST_W-1:0]          status_o,
  output logic [bdq_pkg::CNT_W-1:0]         count_o
);

  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .result_value_o (result_value_o),
    .position_o     (position_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

endmodule

// ===== tb/bounded_deque_with_search_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb
// self-checking testbench of the bounded deque with search: directed corner
// requests (empty and full store, extreme values, no-op codes, first-match
// search), then random bursts that grow and shrink the store, under three
// traffic mixes, two long output hold-offs and pauses until the block is idle;
// every result is checked against a cycle-free model of the deque
// ----------------------------------------------------------------------------
module bounded_deque_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = bdq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int MODE_SPAN       = 570;
  localparam int RX_HOLD_CYCLES  = 150;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_REPORTS     = 10;

  localparam logic [bdq_pkg::OP_W-1:0] OP_NOP_5 = 3'd5;
  localparam logic [bdq_pkg::OP_W-1:0] OP_NOP_6 = 3'd6;
  localparam logic [bdq_pkg::OP_W-1:0] OP_NOP_7 = 3'd7;

  typedef enum logic [1:0] {
    MODE_RX_STALLY,
    MODE_TX_GAPPY,
    MODE_FULL_RATE
  } traffic_mode_e;

  typedef struct packed {
    logic [bdq_pkg::OP_W-1:0]          op;
    logic signed [bdq_pkg::DATA_W-1:0] value;
    traffic_mode_e                     mode;
    logic                              wait_idle;
    logic                              hold_rx;
  } deque_request_t;

  typedef struct packed {
    logic signed [bdq_pkg::DATA_W-1:0] result_value;
    logic [bdq_pkg::POS_W-1:0]         position;
    logic [bdq_pkg::ST_W-1:0]          status;
    logic [bdq_pkg::CNT_W-1:0]         count;
  } deque_result_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic [bdq_pkg::OP_W-1:0]          operation_i    = '0;
  logic signed [bdq_pkg::DATA_W-1:0] value_i        = '0;
  logic                              out_stall_i    = 1'b0;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic signed [bdq_pkg::DATA_W-1:0] result_value_o;
  logic [bdq_pkg::POS_W-1:0]         position_o;
  logic [bdq_pkg::ST_W-1:0]          status_o;
  logic [bdq_pkg::CNT_W-1:0]         count_o;

  deque_request_t pending_q[$];
  deque_result_t  expected_q[$];
  deque_request_t head_req;

  logic signed [bdq_pkg::DATA_W-1:0] deque_ring [DEPTH];
  int unsigned                       head_slot  = 0;
  int unsigned                       fill_level = 0;

  traffic_mode_e gen_mode        = MODE_RX_STALLY;
  traffic_mode_e cur_mode        = MODE_RX_STALLY;
  bit            req_accepted    = 1'b0;
  int unsigned   rx_hold_tokens  = 0;
  int unsigned   rx_holds_served = 0;
  int unsigned   rx_hold_left    = 0;
  int unsigned   stuck_cycles    = 0;
  int unsigned   error_count     = 0;

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .position_o    (position_o),
    .status_o      (status_o),
    .count_o       (count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_pct(traffic_mode_e mode, bit rx_side);
    case (mode)
      MODE_RX_STALLY: return rx_side ? 45 : 11;
      MODE_TX_GAPPY:  return rx_side ? 11 : 45;
      default:        return 0;
    endcase
  endfunction

  function automatic deque_result_t deque_apply(logic [bdq_pkg::OP_W-1:0] op,
                                                logic signed [bdq_pkg::DATA_W-1:0] value);
    deque_result_t r;
    int unsigned   k;
    bit            hit;
    r      = '0;
    r.status = bdq_pkg::ST_OK;
    hit    = 1'b0;
    case (op) inside
      bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          deque_ring[head_slot] = value;
          fill_level++;
        end else begin
          deque_ring[(head_slot + fill_level) % DEPTH] = value;
          fill_level++;
        end
      end
      bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else if (op == bdq_pkg::OP_POP_FRONT) begin
          r.result_value = deque_ring[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          fill_level--;
        end else begin
          r.result_value = deque_ring[(head_slot + fill_level - 1) % DEPTH];
          fill_level--;
        end
      end
      bdq_pkg::OP_SEARCH: begin
        for (k = 0; k < fill_level; k++) begin
          if (!hit && deque_ring[(head_slot + k) % DEPTH] == value) begin
            hit = 1'b1;
            r.position = bdq_pkg::POS_W'(k);
          end
        end
        if (!hit) r.status = bdq_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.count = bdq_pkg::CNT_W'(fill_level);
    return r;
  endfunction

  function automatic logic signed [bdq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:             return 32'sh7FFF_FFFF;
      1:             return 32'sh8000_0000;
      2:             return -32'sd1;
      3, 4, 5, 6:    return $urandom_range(7);
      default:       return $urandom();
    endcase
  endfunction

  task automatic queue_request(logic [bdq_pkg::OP_W-1:0] op,
                               logic signed [bdq_pkg::DATA_W-1:0] value,
                               bit wait_idle, bit hold_rx);
    deque_request_t req;
    req.op        = op;
    req.value     = value;
    req.mode      = gen_mode;
    req.wait_idle = wait_idle;
    req.hold_rx   = hold_rx;
    pending_q.push_back(req);
  endtask

  task automatic flag_error(string what, deque_result_t want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t %s: expected value %0d pos %0d status %0d count %0d,", $time, what,
               want.result_value, want.position, want.status, want.count);
      $display("    got value %0d pos %0d status %0d count %0d",
               result_value_o, position_o, status_o, count_o);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_accepted)) begin
      if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        head_req = pending_q[0];
        if ((head_req.wait_idle && expected_q.size() != 0) ||
            $urandom_range(99) < idle_pct(head_req.mode, 1'b0)) begin
          in_valid_i <= 1'b0;
        end else begin
          void'(pending_q.pop_front());
          in_valid_i  <= 1'b1;
          operation_i <= head_req.op;
          value_i     <= head_req.value;
          cur_mode    <= head_req.mode;
          if (head_req.hold_rx) rx_hold_tokens <= rx_hold_tokens + 1;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_holds_served != rx_hold_tokens) begin
      out_stall_i     <= 1'b1;
      rx_hold_left    <= RX_HOLD_CYCLES;
      rx_holds_served <= rx_holds_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct(cur_mode, 1'b1));
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    deque_result_t want;
    bit            result_taken;
    req_accepted = in_valid_i && !in_stall_o;
    result_taken = out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (result_taken) begin
        if (expected_q.size() == 0) begin
          flag_error("result with no request pending", '0);
        end else begin
          want = expected_q.pop_front();
          if (result_value_o !== want.result_value || position_o !== want.position ||
              status_o !== want.status || count_o !== want.count)
            flag_error("result mismatch", want);
        end
      end
      if (req_accepted) expected_q.push_back(deque_apply(operation_i, value_i));
      if (req_accepted || result_taken) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  initial begin
    int            i;
    int            n;
    int            burst_len;
    int unsigned   burst_kind;
    int unsigned   roll;
    logic [bdq_pkg::OP_W-1:0]          op;
    logic signed [bdq_pkg::DATA_W-1:0] fill_value;

    // directed: empty store, no-op codes, fill to full, push on full, search, pop
    gen_mode = MODE_RX_STALLY;
    queue_request(bdq_pkg::OP_POP_FRONT, 32'sd0, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_POP_BACK, 32'sd0, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_SEARCH, 32'sd0, 1'b0, 1'b0);
    queue_request(OP_NOP_5, -32'sd1, 1'b0, 1'b0);
    queue_request(OP_NOP_7, 32'sh8000_0000, 1'b0, 1'b0);
    for (i = 0; i < DEPTH; i++) begin
      case (i % 6)
        0:       fill_value = 32'sh7FFF_FFFF;
        1:       fill_value = 32'sh8000_0000;
        2:       fill_value = -32'sd1;
        3:       fill_value = 32'sd0;
        4:       fill_value = 32'sh5555_5555;
        default: fill_value = 32'shAAAA_AAAA;
      endcase
      queue_request(i[0] ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT, fill_value,
                    1'b0, 1'b0);
    end
    queue_request(bdq_pkg::OP_PUSH_FRONT, 32'sd1, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_PUSH_BACK, 32'sd2, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_SEARCH, 32'shAAAA_AAAA, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_SEARCH, 32'sd12345, 1'b0, 1'b0);
    queue_request(OP_NOP_6, 32'sd0, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_POP_FRONT, 32'sd0, 1'b0, 1'b0);
    queue_request(bdq_pkg::OP_POP_BACK, 32'sd0, 1'b0, 1'b0);

    // random bursts that push the store toward full or empty, or keep it balanced
    n = 0;
    while (n < RANDOM_REQUESTS) begin
      burst_kind = $urandom_range(2);
      burst_len  = $urandom_range(4, 40);
      for (i = 0; i < burst_len && n < RANDOM_REQUESTS; i++) begin
        roll = $urandom_range(99);
        if (roll < (burst_kind == 0 ? 65 : burst_kind == 1 ? 20 : 35))
          op = $urandom_range(1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
        else if (roll < (burst_kind == 0 ? 80 : burst_kind == 1 ? 75 : 70))
          op = $urandom_range(1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
        else if (roll < 96)
          op = bdq_pkg::OP_SEARCH;
        else
          case ($urandom_range(2))
            0:       op = OP_NOP_5;
            1:       op = OP_NOP_6;
            default: op = OP_NOP_7;
          endcase
        gen_mode = (n < MODE_SPAN) ? MODE_RX_STALLY :
                   (n < 2 * MODE_SPAN) ? MODE_TX_GAPPY : MODE_FULL_RATE;
        queue_request(op, pick_value(),
                      (n == MODE_SPAN || n == 2 * MODE_SPAN || n % 400 == 399),
                      (n == 250 || n == 1400));
        n++;
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) &&
           stuck_cycles < WATCHDOG_CYCLES)
      @(posedge clk_i);

    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      if (error_count == 0 && expected_q.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule
